// ===== sv/afc_pkg.sv =====
package afc_pkg;

   // Six frustum planes, one configuration register each
   localparam int NUM_PLANES = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int PLANE_W    = 64;

   // Width of the exact -r <= s - d test: s + r - d kept in 35 signed bits
   localparam int ACC_W      = 35;
   localparam int DIST_SHIFT = 14;

   // Request and response payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 8;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      PLANE_LEFT   = 3'd0,
      PLANE_RIGHT  = 3'd1,
      PLANE_TOP    = 3'd2,
      PLANE_BOTTOM = 3'd3,
      PLANE_NEAR   = 3'd4,
      PLANE_FAR    = 3'd5
   } plane_idx_type;

   // One box, last field in the lowest bits
   typedef struct packed {
      logic        [14:0] half_z;
      logic        [14:0] half_y;
      logic        [14:0] half_x;
      logic signed [15:0] center_z;
      logic signed [15:0] center_y;
      logic signed [15:0] center_x;
   } box_type;

   // One plane register, normal x in the lowest bits
   typedef struct packed {
      logic signed [15:0] offset;
      logic signed [15:0] norm_z;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_x;
   } plane_type;

   // Data handed from one cell to the next
   typedef struct packed {
      box_type box;
      logic    vis;
   } link_type;

endpackage

// ===== sv/aabb_frustum_cull_test_top.sv =====
// Box versus view frustum test. Each request transaction carries one
// axis-aligned box (centre in signed Q8.8, half-extents in unsigned Q7.8);
// the response carries visible = 1 when the box lies on or in front of all
// six planes written through the csr port (normal x, y, z in Q1.14, then
// distance in Q8.8, index 0 to 5 = left, right, top, bottom, near, far;
// other indexes are ignored, all planes reset to zero so every box passes).
// The arithmetic is exact. One box is taken every cycle while the response
// is not stalled; each of the six plane cells in the chain has a product
// stage and a sum stage. Write planes only while no box is in flight.
module aabb_frustum_cull_test_top
   import afc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PLANE_W-1:0]    csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center_x[15:0], center_y[31:16], center_z[47:32],
   // half_x[62:48], half_y[77:63], half_z[92:78], zero[95:93]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // visible[0], zero[7:1]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic     chain_valid [NUM_PLANES+1];
   logic     chain_ready [NUM_PLANES+1];
   link_type chain_data  [NUM_PLANES+1];

   // Enter the chain with every box assumed visible
   assign chain_valid[0]     = req_tvalid;
   assign req_tready         = chain_ready[0];
   assign chain_data[0].box  = box_type'(req_tdata[$bits(box_type)-1:0]);
   assign chain_data[0].vis  = 1'b1;

   // One cell per plane
   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      afc_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_we    (csr_we),
         .csr_index (csr_index),
         .csr_wdata (csr_wdata),
         .up_valid  (chain_valid[g]),
         .up_ready  (chain_ready[g]),
         .up_data   (chain_data[g]),
         .dn_valid  (chain_valid[g+1]),
         .dn_ready  (chain_ready[g+1]),
         .dn_data   (chain_data[g+1])
      );
   end

   // Last cell's register drives the response
   assign rsp_tvalid                 = chain_valid[NUM_PLANES];
   assign chain_ready[NUM_PLANES]    = rsp_tready;
   assign rsp_tdata = {(RSP_DATA_W-1)'(0), chain_data[NUM_PLANES].vis};

endmodule

// ===== sv/afc_cell.sv =====
module afc_cell
   import afc_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PLANE_W-1:0]   csr_wdata,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  link_type             up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output link_type             dn_data
);

   plane_type          plane_ff;
   logic               va_ff, va_in;
   logic               vb_ff, vb_in;
   link_type           la_ff;
   link_type           lb_ff, lb_in;
   logic        [30:0] r_ff [3];
   logic        [30:0] r_in [3];
   logic signed [31:0] s_ff [3];
   logic signed [31:0] s_in [3];
   logic        [15:0] mag  [3];
   logic signed [15:0] norm [3];
   logic        [14:0] half [3];
   logic signed [15:0] cen  [3];
   logic signed [ACC_W-1:0] acc;
   logic               load_a;
   logic               load_b;

   // Hold this cell's plane
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr_we && (csr_index == CSR_IDX_W'(CELL_IDX))) begin
         plane_ff <= plane_type'(csr_wdata);
      end
   end

   // Advance a stage when it is empty or the stage below takes its transaction
   assign load_b   = !vb_ff || dn_ready;
   assign load_a   = !va_ff || load_b;
   assign up_ready = load_a;

   // Stage A: six products of normal and box
   always_comb begin
      norm[0] = plane_ff.norm_x;
      norm[1] = plane_ff.norm_y;
      norm[2] = plane_ff.norm_z;
      half[0] = up_data.box.half_x;
      half[1] = up_data.box.half_y;
      half[2] = up_data.box.half_z;
      cen[0]  = up_data.box.center_x;
      cen[1]  = up_data.box.center_y;
      cen[2]  = up_data.box.center_z;
      for (int i = 0; i < 3; i++) begin
         // most negative normal maps to 0x8000, exactly 2.0
         mag[i]  = norm[i][15] ? (~norm[i] + 16'd1) : norm[i];
         r_in[i] = 31'(half[i]) * 31'(mag[i]);
         s_in[i] = 32'(norm[i]) * 32'(cen[i]);
      end
      va_in = load_a ? up_valid : va_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         la_ff <= up_data;
         r_ff  <= r_in;
         s_ff  <= s_in;
      end
   end

   // Stage B: s + r - d >= 0 is the same test as -r <= s - d
   always_comb begin
      acc = ACC_W'(s_ff[0]) + ACC_W'(s_ff[1]) + ACC_W'(s_ff[2])
          + ACC_W'(r_ff[0]) + ACC_W'(r_ff[1]) + ACC_W'(r_ff[2])
          - (ACC_W'(plane_ff.offset) <<< DIST_SHIFT);
      lb_in     = la_ff;
      lb_in.vis = la_ff.vis && !acc[ACC_W-1];
      vb_in     = load_b ? va_ff : vb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         lb_ff <= lb_in;
      end
   end

   assign dn_valid = vb_ff;
   assign dn_data  = lb_ff;

endmodule

// ===== sv/afc_check.sv =====
module afc_check
   import afc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [PLANE_W-1:0]    csr_wdata,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Empty chain after reset: nothing to send, ready for a transaction
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("chain not empty after reset");

   // Free last stage lets every stage above move
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled with free output stage");

   // Padding bits of the response stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:1] == '0))
      else $error("response padding not zero");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind aabb_frustum_cull_test_top afc_check u_afc_check (.*);
